### design/kfs_pkg.sv
// Shared constants and types for the key frequency statistics block.
package kfs_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 256;
	localparam int unsigned KEY_BITS_DEF    = 64;
	localparam int unsigned COUNT_BITS_DEF  = 24;

	localparam int unsigned USER_KEY_W  = 64;
	localparam int unsigned COUNT_W     = 24;
	localparam int unsigned MEAN_W      = 32;
	localparam int unsigned DISTINCT_W  = 9;
	localparam int unsigned FRAC_BITS   = 8;

	// One queued record after the front end has masked the key.
	typedef struct packed {
		logic [USER_KEY_W-1:0] key;
		logic                  last;
	} item_t;

	// Handshake between the front queue and the back sequencer.
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

### design/kfs_if.sv
// Channel interfaces for records in and statistics out.
interface kfs_in_if;
	logic                          valid;
	logic                          ready;
	logic [kfs_pkg::USER_KEY_W-1:0] user_key;
	logic                          last_item;

	modport source (output valid, output user_key, output last_item, input ready);
	modport sink (input valid, input user_key, input last_item, output ready);
endinterface

interface kfs_out_if;
	logic                           valid;
	logic                           ready;
	logic [kfs_pkg::COUNT_W-1:0]    min_count;
	logic [kfs_pkg::COUNT_W-1:0]    max_count;
	logic [kfs_pkg::MEAN_W-1:0]     mean_fixed;
	logic [kfs_pkg::DISTINCT_W-1:0] distinct_keys;
	logic [kfs_pkg::COUNT_W-1:0]    total_items;
	logic                           empty_flag;
	logic                           overflow_flag;

	modport source (output valid, output min_count, output max_count, output mean_fixed,
		output distinct_keys, output total_items, output empty_flag, output overflow_flag,
		input ready);
	modport sink (input valid, input min_count, input max_count, input mean_fixed,
		input distinct_keys, input total_items, input empty_flag, input overflow_flag,
		output ready);
endinterface

### design/kfs_front.sv
// Front end: accepts records, masks the key and holds them in a two-word queue.
module kfs_front #(
	parameter int unsigned KEY_BITS = kfs_pkg::KEY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	kfs_in_if.sink               in_ch,
	output kfs_pkg::queue_head_t head,
	input  logic                 pop
);
	localparam logic [kfs_pkg::USER_KEY_W-1:0] KeyMask =
		{kfs_pkg::USER_KEY_W{1'b1}} >> (kfs_pkg::USER_KEY_W - KEY_BITS);

	kfs_pkg::item_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           push;
	logic           do_pop;

	assign in_ch.ready = (fill_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign do_pop      = pop && (fill_q != 2'd0);
	assign head.valid  = (fill_q != 2'd0);
	assign head.item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !do_pop) fill_q <= fill_q + 2'd1;
			else if (!push && do_pop) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].key  <= in_ch.user_key & KeyMask;
			slot_q[wr_ptr_q].last <= in_ch.last_item;
		end
	end
endmodule

### design/kfs_div.sv
// Restoring divider that retires one quotient bit per cycle.
module kfs_div #(
	parameter int unsigned QW = 32,
	parameter int unsigned VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [QW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [QW-1:0] quotient
);
	localparam int unsigned CW = $clog2(QW + 1);

	logic [QW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [CW-1:0] left_q;
	logic          busy_q;
	logic [VW:0]   rem_sh;
	logic [VW:0]   rem_sub;
	logic          fits;

	assign rem_sh   = {rem_q, dvd_q[QW-1]};
	assign rem_sub  = rem_sh - {1'b0, dsr_q};
	assign fits     = (rem_sh >= {1'b0, dsr_q});
	assign busy     = busy_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			left_q <= CW'(QW);
		end else if (busy_q) begin
			left_q <= left_q - CW'(1);
			if (left_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
			dvd_q <= {dvd_q[QW-2:0], fits};
		end
	end
endmodule

### design/kfs_back.sv
// Back end: table search and update, end-of-set scan, mean and result register.
module kfs_back #(
	parameter int unsigned TABLE_DEPTH = kfs_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned KEY_BITS    = kfs_pkg::KEY_BITS_DEF,
	parameter int unsigned COUNT_BITS  = kfs_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kfs_pkg::queue_head_t head,
	output logic                 pop,
	kfs_out_if.source            out_ch
);
	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned IW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned QW = COUNT_BITS + kfs_pkg::FRAC_BITS;

	typedef enum logic [2:0] {
		B_IDLE, B_SEARCH, B_HIT, B_MISS, B_SCAN, B_DIV_GO, B_DIV_WAIT, B_OUT
	} state_t;

	state_t                state_q;
	logic [KEY_BITS-1:0]   key_q;
	logic                  last_q;
	logic [IW-1:0]         idx_q;
	logic                  pend_q;
	logic [AW-1:0]         pidx_q;
	logic [AW-1:0]         hit_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [IW-1:0]         used_q;
	logic [COUNT_BITS-1:0] items_q;
	logic                  drop_q;
	logic [COUNT_BITS-1:0] lo_q;
	logic [COUNT_BITS-1:0] hi_q;
	logic                  first_q;

	logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];
	logic [KEY_BITS-1:0]   rd_key_s1;
	logic [COUNT_BITS-1:0] rd_cnt_s1;

	logic                  we;
	logic [AW-1:0]         waddr;
	logic [COUNT_BITS-1:0] wcnt;
	logic                  issue;
	logic                  table_full;
	logic [COUNT_BITS-1:0] items_inc;
	logic                  div_start;
	logic                  div_busy;
	logic [QW-1:0]         div_quot;
	logic [39:0]           quot_wide;
	logic [31:0]           lo_wide;
	logic [31:0]           hi_wide;
	logic [31:0]           items_wide;
	logic [31:0]           used_wide;
	logic                  out_free;

	logic                  ov_q;
	logic [kfs_pkg::COUNT_W-1:0]    o_min_q;
	logic [kfs_pkg::COUNT_W-1:0]    o_max_q;
	logic [kfs_pkg::MEAN_W-1:0]     o_mean_q;
	logic [kfs_pkg::DISTINCT_W-1:0] o_dist_q;
	logic [kfs_pkg::COUNT_W-1:0]    o_tot_q;
	logic                           o_empty_q;
	logic                           o_drop_q;

	assign issue      = (idx_q < used_q);
	assign table_full = (used_q == IW'(TABLE_DEPTH));
	assign items_inc  = (items_q == '1) ? items_q : items_q + COUNT_BITS'(1);
	assign pop        = (state_q == B_IDLE) && head.valid;
	assign div_start  = (state_q == B_DIV_GO);
	assign out_free   = !ov_q || out_ch.ready;

	always_comb begin
		we    = 1'b0;
		waddr = hit_q;
		wcnt  = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
		case (state_q)
			B_HIT: we = 1'b1;
			B_MISS: begin
				we    = !table_full;
				waddr = used_q[AW-1:0];
				wcnt  = COUNT_BITS'(1);
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= key_q;
			cnt_mem[waddr] <= wcnt;
		end
		rd_key_s1 <= key_mem[idx_q[AW-1:0]];
		rd_cnt_s1 <= cnt_mem[idx_q[AW-1:0]];
	end

	kfs_div #(.QW(QW), .VW(IW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({items_q, kfs_pkg::FRAC_BITS'(0)}),
		.divisor  (used_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign quot_wide  = 40'(div_quot);
	assign lo_wide    = 32'(lo_q);
	assign hi_wide    = 32'(hi_q);
	assign items_wide = 32'(items_q);
	assign used_wide  = 32'(used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			used_q  <= '0;
			items_q <= '0;
			drop_q  <= 1'b0;
			pend_q  <= 1'b0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && out_ch.ready && state_q != B_OUT) ov_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (head.valid) begin
						key_q   <= head.item.key[KEY_BITS-1:0];
						last_q  <= head.item.last;
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= B_SEARCH;
					end
				end
				B_SEARCH: begin
					// Read data is registered, so it arrives in the cycle after its address; pidx_q names it.
					if (pend_q && rd_key_s1 == key_q) begin
						hit_q   <= pidx_q;
						cnt_q   <= rd_cnt_s1;
						pend_q  <= 1'b0;
						state_q <= B_HIT;
					end else if (!pend_q && !issue) begin
						state_q <= B_MISS;
					end else begin
						pend_q <= issue;
						pidx_q <= idx_q[AW-1:0];
						if (issue) idx_q <= idx_q + IW'(1);
					end
				end
				B_HIT, B_MISS: begin
					if (state_q == B_HIT || !table_full) items_q <= items_inc;
					if (state_q == B_MISS) begin
						if (table_full) drop_q <= 1'b1;
						else used_q <= used_q + IW'(1);
					end
					idx_q   <= '0;
					pend_q  <= 1'b0;
					first_q <= 1'b1;
					lo_q    <= '0;
					hi_q    <= '0;
					state_q <= last_q ? B_SCAN : B_IDLE;
				end
				B_SCAN: begin
					if (pend_q) begin
						first_q <= 1'b0;
						if (first_q || rd_cnt_s1 < lo_q) lo_q <= rd_cnt_s1;
						if (first_q || rd_cnt_s1 > hi_q) hi_q <= rd_cnt_s1;
					end
					if (!pend_q && !issue) begin
						state_q <= (used_q == '0) ? B_OUT : B_DIV_GO;
					end else begin
						pend_q <= issue;
						if (issue) idx_q <= idx_q + IW'(1);
					end
				end
				B_DIV_GO: state_q <= B_DIV_WAIT;
				B_DIV_WAIT: if (!div_busy) state_q <= B_OUT;
				B_OUT: begin
					if (out_free) begin
						ov_q      <= 1'b1;
						o_min_q   <= lo_wide[kfs_pkg::COUNT_W-1:0];
						o_max_q   <= hi_wide[kfs_pkg::COUNT_W-1:0];
						o_tot_q   <= items_wide[kfs_pkg::COUNT_W-1:0];
						o_dist_q  <= used_wide[kfs_pkg::DISTINCT_W-1:0];
						o_empty_q <= (used_q == '0);
						o_drop_q  <= drop_q;
						if (used_q == '0) o_mean_q <= '0;
						else if (|quot_wide[39:32]) o_mean_q <= '1;
						else o_mean_q <= quot_wide[31:0];
						used_q  <= '0;
						items_q <= '0;
						drop_q  <= 1'b0;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.min_count     = o_min_q;
	assign out_ch.max_count     = o_max_q;
	assign out_ch.mean_fixed    = o_mean_q;
	assign out_ch.distinct_keys = o_dist_q;
	assign out_ch.total_items   = o_tot_q;
	assign out_ch.empty_flag    = o_empty_q;
	assign out_ch.overflow_flag = o_drop_q;
endmodule

### design/key_frequency_stats_core.sv
// Top level of the key frequency statistics block.
// Usage: records arrive on in_ch (user_key, last_item) with a valid/ready
// handshake; one word of statistics leaves on out_ch after each record that
// has last_item set. A two-word queue in the front end takes records while
// the back end is busy. The back end searches the key table, held in
// synchronous key and count memories, one entry per cycle, over the N
// distinct keys held (at most TABLE_DEPTH). A last record adds a scan of
// the held entries for the minimum and maximum, a division for the mean
// (skipped when the table is empty) and a load of the result register.
// After reset the table is empty and no clearing pass is needed; entries
// above the fill count are never used. The table clears after each report.
// When the receiver stalls, the result stays in the output register; the
// back end keeps counting records and waits only when a second report is
// due, and the front end stalls once its queue is full.
module key_frequency_stats_core #(
	parameter int unsigned TABLE_DEPTH = kfs_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned KEY_BITS    = kfs_pkg::KEY_BITS_DEF,
	parameter int unsigned COUNT_BITS  = kfs_pkg::COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	kfs_in_if.sink    in_ch,
	kfs_out_if.source out_ch
);
	kfs_pkg::queue_head_t head;
	logic                 pop;

	kfs_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.head   (head),
		.pop    (pop)
	);

	kfs_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);
endmodule

### test/kfs_checker.sv
// Checker for the key frequency statistics block: predicts each report and compares it.
`timescale 1ns / 1ps
module kfs_checker (
	input  logic   clk,
	input  logic   arst_n,
	kfs_in_if      in_ch,
	kfs_out_if     out_ch,
	output int     fail_count,
	output int     pending_reports
);
	localparam int unsigned DEPTH = kfs_pkg::TABLE_DEPTH_DEF;
	localparam logic [kfs_pkg::COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [kfs_pkg::COUNT_W-1:0]    min_count;
		logic [kfs_pkg::COUNT_W-1:0]    max_count;
		logic [kfs_pkg::MEAN_W-1:0]     mean_fixed;
		logic [kfs_pkg::DISTINCT_W-1:0] distinct_keys;
		logic [kfs_pkg::COUNT_W-1:0]    total_items;
		logic                           empty_flag;
		logic                           overflow_flag;
	} report_t;

	logic [kfs_pkg::USER_KEY_W-1:0] key_table [DEPTH];
	logic [kfs_pkg::COUNT_W-1:0]    key_count [DEPTH];
	int unsigned                    keys_held;
	logic [kfs_pkg::COUNT_W-1:0]    records_counted;
	logic                           any_dropped;
	report_t                        report_queue [$];

	assign pending_reports = report_queue.size();

	// Counts one record; on a last record returns the report and clears the table.
	function automatic bit tally_record(input logic [kfs_pkg::USER_KEY_W-1:0] key,
			input logic last, output report_t rep);
		bit hit;
		longint unsigned mean;
		hit = 0;
		rep = '0;
		for (int i = 0; i < keys_held; i++) begin
			if (!hit && key_table[i] == key) begin
				hit = 1;
				if (key_count[i] != COUNT_MAX) key_count[i]++;
				if (records_counted != COUNT_MAX) records_counted++;
			end
		end
		if (!hit) begin
			if (keys_held < DEPTH) begin
				key_table[keys_held] = key;
				key_count[keys_held] = 1;
				keys_held++;
				if (records_counted != COUNT_MAX) records_counted++;
			end else begin
				any_dropped = 1;
			end
		end
		if (!last) return 0;
		for (int i = 0; i < keys_held; i++) begin
			if (i == 0 || key_count[i] < rep.min_count) rep.min_count = key_count[i];
			if (i == 0 || key_count[i] > rep.max_count) rep.max_count = key_count[i];
		end
		if (keys_held != 0) begin
			mean = (longint'(records_counted) << kfs_pkg::FRAC_BITS) / keys_held;
			rep.mean_fixed = (mean > 64'hFFFF_FFFF) ? '1 : mean[kfs_pkg::MEAN_W-1:0];
		end
		rep.distinct_keys = keys_held[kfs_pkg::DISTINCT_W-1:0];
		rep.total_items = records_counted;
		rep.empty_flag = (keys_held == 0);
		rep.overflow_flag = any_dropped;
		keys_held = 0;
		records_counted = '0;
		any_dropped = 0;
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t rep;
		report_t exp;
		if (!arst_n) begin
			keys_held = 0;
			records_counted = '0;
			any_dropped = 0;
			fail_count = 0;
			report_queue.delete();
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (tally_record(in_ch.user_key, in_ch.last_item, rep))
					report_queue.push_back(rep);
			end
			if (out_ch.valid && out_ch.ready) begin
				if (report_queue.size() == 0) begin
					$error("report word with no report expected");
					fail_count++;
				end else begin
					exp = report_queue.pop_front();
					if (out_ch.min_count !== exp.min_count) begin
						$error("min_count: expected %0d, got %0d", exp.min_count, out_ch.min_count);
						fail_count++;
					end
					if (out_ch.max_count !== exp.max_count) begin
						$error("max_count: expected %0d, got %0d", exp.max_count, out_ch.max_count);
						fail_count++;
					end
					if (out_ch.mean_fixed !== exp.mean_fixed) begin
						$error("mean_fixed: expected %0d, got %0d", exp.mean_fixed,
							out_ch.mean_fixed);
						fail_count++;
					end
					if (out_ch.distinct_keys !== exp.distinct_keys) begin
						$error("distinct_keys: expected %0d, got %0d", exp.distinct_keys,
							out_ch.distinct_keys);
						fail_count++;
					end
					if (out_ch.total_items !== exp.total_items) begin
						$error("total_items: expected %0d, got %0d", exp.total_items,
							out_ch.total_items);
						fail_count++;
					end
					if (out_ch.empty_flag !== exp.empty_flag) begin
						$error("empty_flag: expected %0b, got %0b", exp.empty_flag,
							out_ch.empty_flag);
						fail_count++;
					end
					if (out_ch.overflow_flag !== exp.overflow_flag) begin
						$error("overflow_flag: expected %0b, got %0b", exp.overflow_flag,
							out_ch.overflow_flag);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

### test/tb_key_frequency_stats_core.sv
// Testbench top: drives records into the key frequency statistics block and gives the verdict.
`timescale 1ns / 1ps
module tb_key_frequency_stats_core;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_reports;
	int   idle_cycles;
	bit   quiet_phase;
	int   sink_gap;

	kfs_in_if  in_ch ();
	kfs_out_if out_ch ();

	key_frequency_stats_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	kfs_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.fail_count      (fail_count),
		.pending_reports (pending_reports)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Sends one word and waits until it is taken, with an occasional idle burst first.
	task automatic send_record(input logic [kfs_pkg::USER_KEY_W-1:0] key, input logic last);
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.user_key <= key;
		in_ch.last_item <= last;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// One data set: keys drawn from a pool of the given size, the final one marked last.
	task automatic send_set(input int records, input int pool);
		logic [kfs_pkg::USER_KEY_W-1:0] base;
		base = {$urandom, $urandom};
		for (int i = 0; i < records; i++)
			send_record(base ^ kfs_pkg::USER_KEY_W'($urandom_range(0, pool - 1)),
				i == records - 1);
	endtask

	// Receiver side: random stall bursts, none in the quiet phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			sink_gap <= 0;
		end else if (sink_gap > 0) begin
			out_ch.ready <= 0;
			sink_gap <= sink_gap - 1;
		end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
			out_ch.ready <= 0;
			sink_gap <= $urandom_range(0, 12);
		end else begin
			out_ch.ready <= 1;
		end
	end

	// Watchdog on cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int items;
		quiet_phase = 0;
		in_ch.valid = 0;
		in_ch.user_key = '0;
		in_ch.last_item = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: lone record, extreme keys, repeats and bit-pattern keys.
		send_record('0, 1);
		send_record('1, 1);
		send_record('0, 0);
		send_record('1, 0);
		send_record('0, 0);
		send_record(64'hAAAA_AAAA_AAAA_AAAA, 0);
		send_record(64'h5555_5555_5555_5555, 1);
		for (int i = 0; i < 6; i++) send_record(64'h8000_0000_0000_0001, i == 5);
		// Full table, then dropped new keys and a hit on a held key.
		for (int i = 0; i < 256; i++) send_record(kfs_pkg::USER_KEY_W'(i), 0);
		send_record(64'hDEAD_BEEF_0000_0000, 0);
		send_record(64'hDEAD_BEEF_0000_0001, 0);
		send_record(64'd3, 1);

		items = 0;
		while (items < 880) begin
			int records;
			int pool;
			quiet_phase = (items > 700);
			records = $urandom_range(1, 30);
			pool = (($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 40));
			send_set(records, pool);
			items += records;
		end
		in_ch.valid <= 0;

		while (pending_reports != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
